@@ rtl/core/region_decoded_load_store_memory_core_defines.svh @@
// Assertion helpers for the checker file of this block.
`ifndef REGION_DECODED_LOAD_STORE_MEMORY_CORE_DEFINES_SVH
`define REGION_DECODED_LOAD_STORE_MEMORY_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDLSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rdlsm port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDLSM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rdlsm port check failed");

`endif

@@ rtl/core/rdlsm_pkg.sv @@
package rdlsm_pkg;

	// Region sizes in bytes
	localparam int unsigned PROGRAM_BYTES = 65536;
	localparam int unsigned STACK_BYTES   = 65536;
	localparam int unsigned TLS_BYTES     = 4096;

	localparam logic [31:0] ADDR_MAX = 32'hffff_ffff;

	// Lowest stack address, 2^32 - STACK_BYTES
	localparam logic [32:0] STACK_LO = {1'b0, ADDR_MAX} + 33'd1 - 33'(STACK_BYTES);

	// Physical layout of the shared byte array: program, stack, thread-local
	localparam int unsigned STACK_OFF   = PROGRAM_BYTES;
	localparam int unsigned TLS_OFF     = PROGRAM_BYTES + STACK_BYTES;
	localparam int unsigned TOTAL_BYTES = TLS_OFF + TLS_BYTES;

	// Four byte lanes, one RAM each
	localparam int unsigned LANES     = 4;
	localparam int unsigned ROW_DEPTH = (TOTAL_BYTES + LANES - 1) / LANES;
	localparam int unsigned ROW_W     = $clog2(ROW_DEPTH);
	localparam int unsigned PHYS_W    = ROW_W + 2;

	// Stack offset plus STACK_OFF, modulo 2^32: addr - (2^32 - SB) + SO
	localparam logic [31:0] STACK_ADJ = 32'(STACK_OFF + STACK_BYTES);
	localparam logic [31:0] TLS_ADJ   = 32'(TLS_OFF);

	// Stream payload layout
	localparam int unsigned IN_TDATA_W  = 72;
	localparam int unsigned OUT_TDATA_W = 32;
	localparam int unsigned ADDR_LSB    = 0;
	localparam int unsigned SIZE_LSB    = 32;
	localparam int unsigned SEXT_BIT    = 34;
	localparam int unsigned WDATA_LSB   = 35;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_STORE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		SZ_BYTE = 2'd0,
		SZ_HALF = 2'd1,
		SZ_WORD = 2'd2,
		SZ_BAD  = 2'd3
	} size_t;

	typedef enum logic [0:0] {
		REG_PROGRAM_BASE  = 1'b0,
		REG_PROGRAM_LIMIT = 1'b1
	} reg_idx_t;

	// Decoded access handed from the address decoder to the core
	typedef struct packed {
		logic              fault;
		logic [PHYS_W-1:0] phys;
		logic [1:0]        last_idx;
	} access_t;

endpackage

@@ rtl/core/rdlsm_ram.sv @@
module rdlsm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// At most one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

@@ rtl/core/rdlsm_decode.sv @@
module rdlsm_decode (
	input  logic [31:0]          address,
	input  rdlsm_pkg::size_t     size_code,
	input  logic [31:0]          program_base,
	input  logic [31:0]          program_limit,
	output rdlsm_pkg::access_t   acc
);

	logic [1:0]  last_idx;
	logic [32:0] last;
	logic [31:0] prog_off;
	logic        prog_hit, prog_ok;
	logic        stack_hit, stack_ok;
	logic        tls_hit, tls_ok;
	logic        ok;
	logic [31:0] phys32;

	// Index of the last byte of the access
	always_comb begin
		case (size_code)
			rdlsm_pkg::SZ_BYTE: last_idx = 2'd0;
			rdlsm_pkg::SZ_HALF: last_idx = 2'd1;
			rdlsm_pkg::SZ_WORD: last_idx = 2'd3;
			default:            last_idx = 2'd0;
		endcase
	end

	// Region hits and overrun checks, all in parallel
	always_comb begin
		last      = {1'b0, address} + 33'(last_idx);
		prog_off  = address - program_base;
		prog_hit  = (program_base <= address) && (address <= program_limit);
		prog_ok   = (last <= {1'b0, program_limit})
			&& (({1'b0, prog_off} + 33'(last_idx)) < 33'(rdlsm_pkg::PROGRAM_BYTES));
		stack_hit = {1'b0, address} >= rdlsm_pkg::STACK_LO;
		stack_ok  = !last[32];
		tls_hit   = {1'b0, address} < 33'(rdlsm_pkg::TLS_BYTES);
		tls_ok    = last < 33'(rdlsm_pkg::TLS_BYTES);
	end

	// Priority select: program, then stack, then thread-local
	always_comb begin
		if (prog_hit) begin
			ok     = prog_ok;
			phys32 = prog_off;
		end else if (stack_hit) begin
			ok     = stack_ok;
			phys32 = address + rdlsm_pkg::STACK_ADJ;
		end else if (tls_hit) begin
			ok     = tls_ok;
			phys32 = address + rdlsm_pkg::TLS_ADJ;
		end else begin
			ok     = 1'b0;
			phys32 = '0;
		end
		acc.fault    = (size_code == rdlsm_pkg::SZ_BAD) || !ok;
		acc.phys     = phys32[rdlsm_pkg::PHYS_W-1:0];
		acc.last_idx = last_idx;
	end

endmodule

@@ rtl/core/region_decoded_load_store_memory_core.sv @@
// Byte-addressed little-endian data memory with three decoded regions.
// Slave stream s_*: one load or store per word, opcode on s_tuser.
// Master stream m_*: one result per access, fault flag on m_tuser.
// Configuration: cfg_we writes program_base (index 0) or program_limit
// (index 1) at the clock edge; write only while no access is in flight.
// A result passes the input register, then the registered read of the
// byte-lane RAMs. Throughput: one access per cycle unless m_* stalls,
// set by the single port of each of the four byte-lane RAMs; a word at
// any alignment touches each lane once.
// Reset clears the pipeline valids and restores the program bounds to
// 0x10000 and 0x1ffff; memory contents stay undefined until written.
// When m_tready is low the result holds on m_*; an empty input register
// still takes one access, then s_tready drops until the result leaves.
// Faulting accesses return read_data zero and write nothing.
module region_decoded_load_store_memory_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [31:0] address, [33:32] size_code, [34] signed_load,
	// [66:35] write_data, [71:67] zero
	input  logic [rdlsm_pkg::IN_TDATA_W-1:0]   s_tdata,
	// [0] opcode
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [31:0] read_data
	output logic [rdlsm_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// [0] fault
	output logic                               m_tuser,
	input  logic                               cfg_we,
	input  rdlsm_pkg::reg_idx_t                cfg_index,
	input  logic [31:0]                        cfg_data
);

	logic [31:0] base_q, limit_q;

	logic                valid_s1;
	rdlsm_pkg::op_t      op_s1;
	logic [31:0]         addr_s1;
	rdlsm_pkg::size_t    size_s1;
	logic                sext_s1;
	logic [31:0]         wdata_s1;

	logic                valid_s2;
	logic                fault_s2;
	rdlsm_pkg::op_t      op_s2;
	rdlsm_pkg::size_t    size_s2;
	logic                sext_s2;
	logic [1:0]          rot_s2;

	rdlsm_pkg::access_t  acc;
	logic                adv, mv, do_store;
	logic [1:0]          rot;
	logic [7:0]          lane_rdata [rdlsm_pkg::LANES];
	logic [7:0]          b [rdlsm_pkg::LANES];
	logic [31:0]         raw, read_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= 32'h0001_0000;
			limit_q <= 32'h0001_ffff;
		end else if (cfg_we) begin
			case (cfg_index)
				rdlsm_pkg::REG_PROGRAM_BASE:  base_q  <= cfg_data;
				rdlsm_pkg::REG_PROGRAM_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline handshake
	assign adv      = !valid_s2 || m_tready;
	assign mv       = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= rdlsm_pkg::op_t'(s_tuser);
			addr_s1  <= s_tdata[rdlsm_pkg::ADDR_LSB +: 32];
			size_s1  <= rdlsm_pkg::size_t'(s_tdata[rdlsm_pkg::SIZE_LSB +: 2]);
			sext_s1  <= s_tdata[rdlsm_pkg::SEXT_BIT];
			wdata_s1 <= s_tdata[rdlsm_pkg::WDATA_LSB +: 32];
		end
	end

	rdlsm_decode u_decode (
		.address       (addr_s1),
		.size_code     (size_s1),
		.program_base  (base_q),
		.program_limit (limit_q),
		.acc           (acc)
	);

	assign rot      = acc.phys[1:0];
	assign do_store = mv && (op_s1 == rdlsm_pkg::OP_STORE) && !acc.fault;

	// Byte lanes: lane g holds physical bytes with phys[1:0] == g
	for (genvar g = 0; g < rdlsm_pkg::LANES; g++) begin : g_lane
		logic [1:0]                  idx;
		logic [rdlsm_pkg::ROW_W-1:0] row;
		logic [7:0]                  wbyte;

		always_comb begin
			idx   = 2'(g) - rot;
			row   = acc.phys[rdlsm_pkg::PHYS_W-1:2]
				+ rdlsm_pkg::ROW_W'(2'(g) < rot);
			wbyte = 8'(wdata_s1 >> {idx, 3'b000});
		end

		rdlsm_ram #(
			.WIDTH (8),
			.DEPTH (rdlsm_pkg::ROW_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (do_store && (idx <= acc.last_idx)),
			.re    (mv),
			.addr  (row),
			.wdata (wbyte),
			.rdata (lane_rdata[g])
		);
	end

	// Result stage control, aligned with the RAM read data
	always_ff @(posedge clk) begin
		if (mv) begin
			fault_s2 <= acc.fault;
			op_s2    <= op_s1;
			size_s2  <= size_s1;
			sext_s2  <= sext_s1;
			rot_s2   <= rot;
		end
	end

	// Rotate lanes back into access order, extend, and zero faults and stores
	always_comb begin
		for (int i = 0; i < rdlsm_pkg::LANES; i++) begin
			b[i] = lane_rdata[2'(rot_s2 + 2'(i))];
		end
		raw = {b[3], b[2], b[1], b[0]};
		case (size_s2)
			rdlsm_pkg::SZ_BYTE: read_data = {{24{sext_s2 & raw[7]}}, raw[7:0]};
			rdlsm_pkg::SZ_HALF: read_data = {{16{sext_s2 & raw[15]}}, raw[15:0]};
			rdlsm_pkg::SZ_WORD: read_data = raw;
			default:            read_data = '0;
		endcase
		if (fault_s2 || (op_s2 == rdlsm_pkg::OP_STORE)) begin
			read_data = '0;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = read_data;
	assign m_tuser  = fault_s2;

endmodule

@@ rtl/core/rdlsm_checker.sv @@
`include "region_decoded_load_store_memory_core_defines.svh"

module rdlsm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [rdlsm_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                              m_tuser
);

	// A stalled result holds its payload
	`RDLSM_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// A refused access never carries data
	`RDLSM_ASSERT_IMP(a_fault_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0)

	// A newly valid result follows an accepted word through the input register and the RAM read
	`RDLSM_ASSERT_IMP(a_latency, clk, arst_n, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

	// A draining output never blocks the input side
	`RDLSM_ASSERT_IMP(a_ready_flow, clk, arst_n, m_tready, s_tready)

endmodule

bind region_decoded_load_store_memory_core rdlsm_checker u_rdlsm_checker (.*);

@@ bench/region_decoded_load_store_memory_core_tb.sv @@
module region_decoded_load_store_memory_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rdlsm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 100000;
	localparam int unsigned PHASE_ITEMS = 107;
	localparam int unsigned PHASES      = 7;

	typedef enum {AREA_PROGRAM, AREA_STACK, AREA_TLS} area_e;

	typedef struct packed {
		logic [31:0] read_data;
		logic        fault;
	} mem_result_t;

	// Predicts each access from a private copy of the three stores and the
	// program bounds, then checks results in order against what it predicted.
	class load_store_scoreboard;
		logic [31:0] program_base;
		logic [31:0] program_limit;
		logic [7:0]  prog_mem[PROGRAM_BYTES];
		bit          prog_known[PROGRAM_BYTES];
		logic [7:0]  stack_mem[STACK_BYTES];
		bit          stack_known[STACK_BYTES];
		logic [7:0]  tls_mem[TLS_BYTES];
		bit          tls_known[TLS_BYTES];
		mem_result_t awaited_results[$];
		int unsigned errors, checked, loads, stores, refused;

		function new();
			program_base  = 32'h0001_0000;
			program_limit = 32'h0001_ffff;
		endfunction

		function void set_bounds(logic [31:0] base, logic [31:0] limit);
			program_base  = base;
			program_limit = limit;
		endfunction

		// Region decode by first byte; any byte past the region's end faults
		function bit locate(input logic [31:0] addr, input int unsigned n,
				output area_e area, output int unsigned off);
			longint unsigned a, last, stack_lo, o;
			a        = 64'(addr);
			last     = a + n - 1;
			stack_lo = 64'h1_0000_0000 - STACK_BYTES;
			area     = AREA_TLS;
			off      = 0;
			if (program_base <= addr && addr <= program_limit) begin
				o = a - program_base;
				if (last > program_limit || o + n > PROGRAM_BYTES)
					return 0;
				area = AREA_PROGRAM;
				off  = 32'(o);
				return 1;
			end
			if (a >= stack_lo) begin
				if (last > 64'hffff_ffff)
					return 0;
				area = AREA_STACK;
				off  = 32'(a - stack_lo);
				return 1;
			end
			if (a < TLS_BYTES) begin
				if (last >= TLS_BYTES)
					return 0;
				off = addr;
				return 1;
			end
			return 0;
		endfunction

		function bit byte_known(area_e area, int unsigned off);
			case (area)
				AREA_PROGRAM: return prog_known[off];
				AREA_STACK:   return stack_known[off];
				default:      return tls_known[off];
			endcase
		endfunction

		function logic [7:0] byte_read(area_e area, int unsigned off);
			case (area)
				AREA_PROGRAM: return prog_mem[off];
				AREA_STACK:   return stack_mem[off];
				default:      return tls_mem[off];
			endcase
		endfunction

		function void byte_write(area_e area, int unsigned off, logic [7:0] v);
			case (area)
				AREA_PROGRAM: begin
					prog_mem[off]   = v;
					prog_known[off] = 1'b1;
				end
				AREA_STACK: begin
					stack_mem[off]   = v;
					stack_known[off] = 1'b1;
				end
				default: begin
					tls_mem[off]   = v;
					tls_known[off] = 1'b1;
				end
			endcase
		endfunction

		// True for a load that would succeed but touch a never-written byte
		function bit unsafe_load(op_t op, logic [31:0] addr, size_t sz);
			area_e       area;
			int unsigned off, n, i;
			if (op != OP_LOAD || sz == SZ_BAD)
				return 0;
			n = 1 << sz;
			if (!locate(addr, n, area, off))
				return 0;
			for (i = 0; i < n; i++)
				if (!byte_known(area, off + i))
					return 1;
			return 0;
		endfunction

		function void note_access(op_t op, logic [31:0] addr, size_t sz, logic sext,
				logic [31:0] wdata);
			mem_result_t r;
			area_e       area;
			int unsigned off, n, i;
			logic [31:0] v;
			r.read_data = '0;
			r.fault     = 1'b1;
			if (sz != SZ_BAD) begin
				n = 1 << sz;
				if (locate(addr, n, area, off)) begin
					r.fault = 1'b0;
					if (op == OP_STORE) begin
						for (i = 0; i < n; i++)
							byte_write(area, off + i, wdata[8*i +: 8]);
						stores++;
					end else begin
						v = '0;
						for (i = 0; i < n; i++)
							v[8*i +: 8] = byte_read(area, off + i);
						// sign fill above the top loaded byte
						if (sext && n < 4 && v[8*n-1])
							for (i = n; i < 4; i++)
								v[8*i +: 8] = 8'hff;
						r.read_data = v;
						loads++;
					end
				end
			end
			if (r.fault)
				refused++;
			awaited_results.push_back(r);
		endfunction

		function void check_result(logic [31:0] rd, logic flt);
			mem_result_t want;
			if (awaited_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: read_data %h fault %b", rd, flt);
				return;
			end
			want = awaited_results.pop_front();
			checked++;
			if (rd !== want.read_data || flt !== want.fault) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch on result %0d: expected read_data %h fault %b,",
						" got read_data %h fault %b"},
						checked, want.read_data, want.fault, rd, flt);
			end
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction
	endclass

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       s_tvalid  = 1'b0;
	logic                       s_tready;
	logic [IN_TDATA_W-1:0]      s_tdata   = '0;
	logic                       s_tuser   = 1'b0;
	logic                       m_tvalid;
	logic                       m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0]     m_tdata;
	logic                       m_tuser;
	logic                       cfg_we    = 1'b0;
	reg_idx_t                   cfg_index = REG_PROGRAM_BASE;
	logic [31:0]                cfg_data  = '0;

	load_store_scoreboard sb = new();
	bit                   idle_on = 1'b0;
	logic [31:0]          recent_stores[$];
	int unsigned          settings = 1;

	region_decoded_load_store_memory_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// Drive one access word and wait for it to be taken
	task automatic issue(input op_t op, input logic [31:0] addr, input size_t sz,
			input logic sext, input logic [31:0] wdata);
		op_t kind;
		kind = op;
		// never read a byte that was not written: turn such a load into a store
		if (sb.unsafe_load(op, addr, sz))
			kind = OP_STORE;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {5'b0, wdata, sext, sz, addr};
		do @(posedge clk); while (!s_tready);
		sb.note_access(kind, addr, sz, sext, wdata);
		if (kind == OP_STORE && sz != SZ_BAD) begin
			recent_stores.push_back(addr);
			if (recent_stores.size() > 32)
				void'(recent_stores.pop_front());
		end
	endtask

	// Hold off the sender until every result is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_bounds(logic [31:0] base, logic [31:0] limit);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PROGRAM_BASE;
		cfg_data  <= base;
		@(posedge clk);
		cfg_index <= REG_PROGRAM_LIMIT;
		cfg_data  <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_bounds(base, limit);
		settings++;
	endtask

	// Address inside, or just past, one region: low edge, high edge or anywhere
	function automatic logic [31:0] pick_address(area_e area);
		longint unsigned lo, span, off, win;
		case (area)
			AREA_PROGRAM: begin
				if (sb.program_base > sb.program_limit)
					return $urandom();
				lo   = 64'(sb.program_base);
				span = 64'(sb.program_limit - sb.program_base);
				if (span > PROGRAM_BYTES + 1)
					span = PROGRAM_BYTES + 1;
			end
			AREA_STACK: begin
				lo   = 64'h1_0000_0000 - STACK_BYTES;
				span = STACK_BYTES - 1;
			end
			default: begin
				lo   = 0;
				span = TLS_BYTES + 1;
			end
		endcase
		win = (span < 63) ? span : 63;
		case ($urandom_range(0, 3))
			0, 1:    off = 64'($urandom_range(0, 32'(win)));
			2:       off = span - 64'($urandom_range(0, 32'(win)));
			default: off = 64'($urandom_range(0, 32'(span)));
		endcase
		return 32'(lo + off);
	endfunction

	task automatic random_access();
		op_t         op;
		size_t       sz;
		logic        sext;
		logic [31:0] addr, wdata;
		int unsigned pick;
		pick  = $urandom_range(0, 99);
		op    = op_t'($urandom_range(0, 1));
		sext  = 1'($urandom_range(0, 1));
		sz    = size_t'($urandom_range(0, 2));
		wdata = $urandom();
		case ($urandom_range(0, 7))
			0:       wdata = '0;
			1:       wdata = '1;
			default: ;
		endcase
		if (pick < 12) begin
			// noise: anywhere, any size code
			addr = $urandom();
			sz   = size_t'($urandom_range(0, 3));
		end else begin
			if (pick < 16)
				sz = SZ_BAD;
			if (op == OP_LOAD && recent_stores.size() != 0 && $urandom_range(0, 3) != 0)
				addr = recent_stores[$urandom_range(0, recent_stores.size() - 1)]
					+ $urandom_range(0, 3);
			else
				addr = pick_address(area_e'($urandom_range(0, 2)));
		end
		issue(op, addr, sz, sext, wdata);
	endtask

	// Result sink with random stall bursts
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, sb.pending());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [31:0] bases[PHASES];
		logic [31:0] limits[PHASES];
		// reset bounds, whole space, empty, over the stack top, over the
		// thread-local area, single top byte, back to reset values
		bases  = '{32'h0001_0000, 32'h0000_0000, 32'hffff_ffff, 32'hffff_f000,
			32'h0000_0800, 32'hffff_ffff, 32'h0001_0000};
		limits = '{32'h0001_ffff, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff,
			32'h0000_10ff, 32'hffff_ffff, 32'h0001_ffff};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;

		// Directed: extensions, size codes, region edges, overruns, unmapped
		issue(OP_STORE, 32'h0001_0000, SZ_WORD, 1'b1, 32'h80ff_7f01);
		issue(OP_LOAD,  32'h0001_0000, SZ_BYTE, 1'b1, '0);
		issue(OP_LOAD,  32'h0001_0003, SZ_BYTE, 1'b1, '0);
		issue(OP_LOAD,  32'h0001_0003, SZ_BYTE, 1'b0, '0);
		issue(OP_LOAD,  32'h0001_0002, SZ_HALF, 1'b1, '0);
		issue(OP_LOAD,  32'h0001_0002, SZ_HALF, 1'b0, '0);
		issue(OP_LOAD,  32'h0001_0000, SZ_WORD, 1'b1, '0);
		issue(OP_STORE, 32'h0001_0000, SZ_BAD,  1'b0, 32'hdead_beef);
		issue(OP_LOAD,  32'h0001_0000, SZ_BAD,  1'b1, '0);
		issue(OP_STORE, 32'h0001_fffc, SZ_WORD, 1'b0, 32'hffff_ffff);
		issue(OP_LOAD,  32'h0001_fffe, SZ_HALF, 1'b1, '0);
		issue(OP_STORE, 32'h0001_fffe, SZ_WORD, 1'b0, 32'h1234_5678);
		issue(OP_STORE, 32'hffff_fffc, SZ_WORD, 1'b0, 32'h0000_0000);
		issue(OP_LOAD,  32'hffff_fffc, SZ_WORD, 1'b0, '0);
		issue(OP_STORE, 32'hffff_ffff, SZ_HALF, 1'b0, 32'h0000_5555);
		issue(OP_STORE, 32'hffff_ffff, SZ_BYTE, 1'b0, 32'h0000_00aa);
		issue(OP_LOAD,  32'hffff_ffff, SZ_BYTE, 1'b1, '0);
		issue(OP_STORE, 32'hffff_0000, SZ_HALF, 1'b0, 32'h0000_8001);
		issue(OP_LOAD,  32'hffff_0000, SZ_HALF, 1'b1, '0);
		issue(OP_STORE, 32'h0000_0000, SZ_WORD, 1'b0, 32'h7fff_8000);
		issue(OP_LOAD,  32'h0000_0000, SZ_HALF, 1'b1, '0);
		issue(OP_STORE, 32'h0000_0ffc, SZ_WORD, 1'b0, 32'hc3c3_3c3c);
		issue(OP_STORE, 32'h0000_0fff, SZ_HALF, 1'b0, 32'h0000_ffff);
		issue(OP_LOAD,  32'h0000_1000, SZ_BYTE, 1'b0, '0);
		issue(OP_LOAD,  32'h0002_0000, SZ_WORD, 1'b0, '0);
		issue(OP_STORE, 32'hffef_ffff, SZ_BYTE, 1'b0, 32'h0000_0001);

		// Random phases, bounds changed only while the pipeline is empty
		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				wait_drained();
				write_bounds(bases[p], limits[p]);
				recent_stores.delete();
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 27 == 0)
					idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
				random_access();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);

		$display("covered %0d accesses: %0d loads, %0d stores, %0d refused, %0d bound settings",
			sb.loads + sb.stores + sb.refused, sb.loads, sb.stores, sb.refused, settings);
		$display("%0d results compared, %0d errors", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ region_decoded_load_store_memory_core.f @@
+incdir+rtl/core
rtl/core/rdlsm_pkg.sv
rtl/core/rdlsm_ram.sv
rtl/core/rdlsm_decode.sv
rtl/core/region_decoded_load_store_memory_core.sv
rtl/core/rdlsm_checker.sv
bench/region_decoded_load_store_memory_core_tb.sv
